### design/energy_meter_with_zero_tracking_core_assert.svh
// Assertion macros for the energy meter RTL.
// Standalone header; included by files that carry concurrent checks.
`ifndef ENERGY_METER_WITH_ZERO_TRACKING_CORE_ASSERT_SVH
`define ENERGY_METER_WITH_ZERO_TRACKING_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EMWZ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("emwz assertion failed");

// Next-cycle implication, disabled during reset.
`define EMWZ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("emwz assertion failed");

`endif

### design/emwz_pkg.sv
// Package for the energy meter core: constants, codes, state and command types.
// No dependencies.
package emwz_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [2:0]  IDX_VOLT  = 3'd4;
  localparam logic [15:0] VOLT_CORR = 16'd111;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ZWIN_LOW  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZWIN_HIGH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ZAVG_LIM  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_VDIV      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MV_PER_A  = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [1:0] {MS_VD, MS_CNT, MS_LO, MS_HI} mul_sel_t;
  typedef enum logic [1:0] {DS_VOLT, DS_ZERO, DS_REPORT} div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_VDIV_GO, ST_VDIV_WAIT, ST_CH_CHECK, ST_ZDIV_GO,
    ST_ZDIV_WAIT, ST_CH_MUL, ST_CH_ACC, ST_SAMPLE_FIN, ST_REP_DEN_MUL, ST_REP_DEN,
    ST_REP_MLO, ST_REP_MHI, ST_REP_ACC, ST_REP_DIV_GO, ST_REP_DIV_WAIT, ST_REP_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic            load;
    logic            div_start;
    div_sel_t        div_sel;
    logic            mul_go;
    mul_sel_t        mul_sel;
    logic            acc_load;
    logic            acc_add;
    logic            den_load;
    logic            v_load;
    logic            energy_add;
    logic            zero_upd;
    logic            zero_fin;
    logic            sample_fin;
    logic            out_load;
    logic            vsel;
    logic [CH_W-1:0] ch;
  } dp_cmd_t;

  typedef struct packed {
    logic opcode;
    logic relay;
    logic in_window;
    logic refresh;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### design/energy_meter_with_zero_tracking_core.sv
// Four-channel energy meter with zero-current tracking, top level.
// Sample: an item takes longer for each relay-on channel and each zero refresh;
// the 64-step shared divider runs once for the voltage and once per refresh.
// Report: a divide per channel and the voltage, plus output wait; one item at a time.
// Synchronous active-high reset restores register defaults and clears all sums.
module energy_meter_with_zero_tracking_core import emwz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [11:0]           current_ch0,
  input  logic [11:0]           current_ch1,
  input  logic [11:0]           current_ch2,
  input  logic [11:0]           current_ch3,
  input  logic [15:0]           line_voltage_code,
  input  logic [3:0]            relay_on_mask,
  input  logic [11:0]           reference_millivolts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            channel_index,
  output logic [31:0]           reported_value,
  output logic                  last_of_report
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  emwz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  emwz_datapath u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .opcode               (opcode),
    .current_ch0          (current_ch0),
    .current_ch1          (current_ch1),
    .current_ch2          (current_ch2),
    .current_ch3          (current_ch3),
    .line_voltage_code    (line_voltage_code),
    .relay_on_mask        (relay_on_mask),
    .reference_millivolts (reference_millivolts),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .channel_index        (channel_index),
    .reported_value       (reported_value),
    .last_of_report       (last_of_report)
  );

endmodule

### design/emwz_div.sv
// Iterative restoring divider, 64-bit dividend and divisor, one bit per cycle.
// Depends on emwz_pkg.
module emwz_div import emwz_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0]          dvd;
  logic [63:0]          dsr;
  logic [64:0]          rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [64:0]          shifted;
  logic [64:0]          diff;

  // Shift in one dividend bit and trial-subtract
  always_comb begin
    shifted = {rem[63:0], dvd[63]};
    diff    = shifted - {1'b0, dsr};
  end

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= (divisor != 64'd0);
      done <= (divisor == 64'd0);
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: a zero divisor yields a zero quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= (divisor == 64'd0) ? 64'd0 : dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (!diff[64]) begin
        rem <= diff;
        dvd <= {dvd[62:0], 1'b1};
      end else begin
        rem <= shifted;
        dvd <= {dvd[62:0], 1'b0};
      end
    end
  end

  assign quotient = dvd;

endmodule

### design/emwz_datapath.sv
// Datapath: configuration, accumulators, zero tracking, shared multiplier and
// divider, output register. Depends on emwz_pkg and emwz_div.
module emwz_datapath import emwz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  opcode,
  input  logic [11:0]           current_ch0,
  input  logic [11:0]           current_ch1,
  input  logic [11:0]           current_ch2,
  input  logic [11:0]           current_ch3,
  input  logic [15:0]           line_voltage_code,
  input  logic [3:0]            relay_on_mask,
  input  logic [11:0]           reference_millivolts,
  input  dp_cmd_t               cmd,
  output dp_status_t            sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            channel_index,
  output logic [31:0]           reported_value,
  output logic                  last_of_report
);

  logic [11:0] zwin_low, zwin_high;
  logic [15:0] zavg_lim, vdiv;
  logic [13:0] mv_per_a;

  logic        item_op;
  logic [11:0] item_cur [CHANNELS];
  logic [15:0] item_vcode;
  logic [3:0]  item_mask;
  logic [11:0] item_vref;

  logic [15:0] v;
  logic [11:0] zero_offset [CHANNELS];
  logic [31:0] zero_sum    [CHANNELS];
  logic [15:0] zero_count  [CHANNELS];
  logic [63:0] energy_sum  [CHANNELS];
  logic [63:0] voltage_sum;
  logic [31:0] sample_count;

  logic [47:0] prod;
  logic [63:0] acc;
  logic [63:0] den;

  logic [11:0] code, zoff, dev;
  logic [15:0] cnt1;
  logic [63:0] src;
  logic [15:0] mul_b_x;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] div_dvd, div_dsr;
  logic        div_done;
  logic [63:0] quotient;
  logic [3:0]  cur_pad [4];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zwin_low  <= 12'd0;
      zwin_high <= 12'd4095;
      zavg_lim  <= 16'd2000;
      vdiv      <= 16'd1;
      mv_per_a  <= 14'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZWIN_LOW:  zwin_low  <= cfg_data[11:0];
        REG_ZWIN_HIGH: zwin_high <= cfg_data[11:0];
        REG_ZAVG_LIM:  zavg_lim  <= cfg_data;
        REG_VDIV:      vdiv      <= cfg_data;
        REG_MV_PER_A:  mv_per_a  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op     <= opcode;
      item_cur[0] <= current_ch0;
      if (CHANNELS > 1) item_cur[1 % CHANNELS] <= current_ch1;
      if (CHANNELS > 2) item_cur[2 % CHANNELS] <= current_ch2;
      if (CHANNELS > 3) item_cur[3 % CHANNELS] <= current_ch3;
      item_vcode  <= line_voltage_code;
      item_mask   <= relay_on_mask;
      item_vref   <= reference_millivolts;
    end
  end

  assign cur_pad = '{4'd0, 4'd0, 4'd0, 4'd0};

  // Per-channel selection
  always_comb begin
    code    = item_cur[cmd.ch];
    zoff    = zero_offset[cmd.ch];
    dev     = (code >= zoff) ? code - zoff : zoff - code;
    cnt1    = zero_count[cmd.ch] + 16'd1;
    src     = cmd.vsel ? voltage_sum : energy_sum[cmd.ch];
    mul_b_x = cmd.vsel ? VOLT_CORR : {4'd0, item_vref};
  end

  // Status toward the controller
  always_comb begin
    sts.opcode    = item_op;
    sts.relay     = item_mask[cmd.ch];
    sts.in_window = (code > zwin_low) && (code < zwin_high);
    sts.refresh   = (cnt1 > zavg_lim) || (cnt1 == 16'hFFFF);
    sts.div_done  = div_done;
    sts.out_free  = !out_valid || !out_stall;
  end

  // Shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MS_VD:   begin mul_a = {16'd0, v};     mul_b = {cur_pad[0], dev}; end
      MS_CNT:  begin mul_a = sample_count;   mul_b = {2'd0, mv_per_a};  end
      MS_LO:   begin mul_a = src[31:0];      mul_b = mul_b_x;           end
      MS_HI:   begin mul_a = src[63:32];     mul_b = mul_b_x;           end
      default: begin mul_a = '0;             mul_b = '0;                end
    endcase
  end

  // Register product, assemble wide product and denominator
  always_ff @(posedge clk) begin
    if (cmd.mul_go)   prod <= mul_a * mul_b;
    if (cmd.acc_load) acc  <= {16'd0, prod};
    else if (cmd.acc_add) acc <= acc + {prod[31:0], 32'd0};
    if (cmd.den_load) den  <= {6'd0, prod[45:0], 12'd0};
    if (cmd.v_load)   v    <= quotient[15:0];
  end

  // Divider operands
  always_comb begin
    case (cmd.div_sel)
      DS_VOLT: begin
        div_dvd = {48'd0, item_vcode};
        div_dsr = {48'd0, (vdiv == 16'd0) ? 16'd1 : vdiv};
      end
      DS_ZERO: begin
        div_dvd = {32'd0, zero_sum[cmd.ch]};
        div_dsr = {48'd0, zero_count[cmd.ch]};
      end
      DS_REPORT: begin
        div_dvd = acc;
        div_dsr = cmd.vsel ? {32'd0, sample_count} : den;
      end
      default: begin
        div_dvd = '0;
        div_dsr = '0;
      end
    endcase
  end

  emwz_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (quotient)
  );

  // Accumulators and zero tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        zero_offset[i] <= '0;
        zero_sum[i]    <= '0;
        zero_count[i]  <= '0;
        energy_sum[i]  <= '0;
      end
      voltage_sum  <= '0;
      sample_count <= '0;
    end else begin
      if (cmd.energy_add)
        energy_sum[cmd.ch] <= energy_sum[cmd.ch] + {16'd0, prod};
      if (cmd.zero_upd) begin
        zero_sum[cmd.ch]   <= zero_sum[cmd.ch] + {20'd0, code};
        zero_count[cmd.ch] <= cnt1;
        if (zoff == 12'd0) zero_offset[cmd.ch] <= code;
      end
      if (cmd.zero_fin) begin
        zero_offset[cmd.ch] <= quotient[11:0];
        zero_sum[cmd.ch]    <= '0;
        zero_count[cmd.ch]  <= '0;
      end
      if (cmd.sample_fin) begin
        voltage_sum  <= voltage_sum + {48'd0, v};
        sample_count <= sample_count + 32'd1;
      end
      // Clear what a report result has just drained
      if (cmd.out_load) begin
        if (cmd.vsel) begin
          voltage_sum  <= '0;
          sample_count <= '0;
        end else begin
          energy_sum[cmd.ch] <= '0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      channel_index  <= cmd.vsel ? IDX_VOLT : 3'(cmd.ch);
      reported_value <= quotient[31:0];
      last_of_report <= cmd.vsel;
    end
  end

endmodule

### design/emwz_ctrl.sv
// Controller state machine sequencing samples and reports over the datapath.
// Depends on emwz_pkg and the assertion macro header.
`include "energy_meter_with_zero_tracking_core_assert.svh"
module emwz_ctrl import emwz_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t     state, state_next;
  logic [CH_W-1:0] ch, ch_next;
  logic            vsel, vsel_next;
  logic            last_ch;

  assign last_ch = (ch == CH_W'(CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= '0;
      vsel  <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      vsel  <= vsel_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    ch_next    = ch;
    vsel_next  = vsel;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        ch_next    = '0;
        vsel_next  = 1'b0;
        state_next = (sts.opcode == OP_REPORT) ? ST_REP_DEN_MUL : ST_VDIV_GO;
      end
      ST_VDIV_GO: state_next = ST_VDIV_WAIT;
      ST_VDIV_WAIT: if (sts.div_done) state_next = ST_CH_CHECK;
      ST_CH_CHECK: begin
        if (sts.relay) begin
          state_next = ST_CH_MUL;
        end else if (sts.in_window && sts.refresh) begin
          state_next = ST_ZDIV_GO;
        end else if (last_ch) begin
          state_next = ST_SAMPLE_FIN;
        end else begin
          ch_next = ch + 1'b1;
        end
      end
      ST_ZDIV_GO: state_next = ST_ZDIV_WAIT;
      ST_ZDIV_WAIT, ST_CH_ACC: begin
        if (state == ST_CH_ACC || sts.div_done) begin
          if (last_ch) begin
            state_next = ST_SAMPLE_FIN;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = ST_CH_CHECK;
          end
        end
      end
      ST_CH_MUL:       state_next = ST_CH_ACC;
      ST_SAMPLE_FIN:   state_next = ST_IDLE;
      ST_REP_DEN_MUL:  state_next = ST_REP_DEN;
      ST_REP_DEN:      state_next = ST_REP_MLO;
      ST_REP_MLO:      state_next = ST_REP_MHI;
      ST_REP_MHI:      state_next = ST_REP_ACC;
      ST_REP_ACC:      state_next = ST_REP_DIV_GO;
      ST_REP_DIV_GO:   state_next = ST_REP_DIV_WAIT;
      ST_REP_DIV_WAIT: if (sts.div_done) state_next = ST_REP_EMIT;
      ST_REP_EMIT: begin
        if (sts.out_free) begin
          if (vsel) begin
            state_next = ST_IDLE;
          end else if (last_ch) begin
            vsel_next  = 1'b1;
            state_next = ST_REP_MLO;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = ST_REP_MLO;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    cmd.ch      = ch;
    cmd.vsel    = vsel;
    cmd.div_sel = DS_VOLT;
    cmd.mul_sel = MS_VD;
    in_stall    = (state != ST_IDLE);
    case (state)
      ST_IDLE:     cmd.load = in_valid;
      ST_VDIV_GO:  cmd.div_start = 1'b1;
      ST_VDIV_WAIT: cmd.v_load = sts.div_done;
      ST_CH_CHECK: cmd.zero_upd = !sts.relay && sts.in_window;
      ST_ZDIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_ZERO;
      end
      ST_ZDIV_WAIT: begin
        cmd.div_sel  = DS_ZERO;
        cmd.zero_fin = sts.div_done;
      end
      ST_CH_MUL:     cmd.mul_go = 1'b1;
      ST_CH_ACC:     cmd.energy_add = 1'b1;
      ST_SAMPLE_FIN: cmd.sample_fin = 1'b1;
      ST_REP_DEN_MUL: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_CNT;
      end
      ST_REP_DEN: cmd.den_load = 1'b1;
      ST_REP_MLO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_LO;
      end
      ST_REP_MHI: begin
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = MS_HI;
        cmd.acc_load = 1'b1;
      end
      ST_REP_ACC: cmd.acc_add = 1'b1;
      ST_REP_DIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_REPORT;
      end
      ST_REP_DIV_WAIT: cmd.div_sel = DS_REPORT;
      ST_REP_EMIT: begin
        cmd.div_sel  = DS_REPORT;
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

  `EMWZ_ASSERT_NXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state == ST_DISPATCH)
  `EMWZ_ASSERT_IMP(a_load_needs_room, clk, rst, cmd.out_load, sts.out_free)
  `EMWZ_ASSERT_NXT(a_vdiv_then_check, clk, rst, state == ST_VDIV_WAIT && sts.div_done, state == ST_CH_CHECK && ch == '0)

endmodule
